@@ rtl/bcpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the Bezier curve point evaluator: item op
// codes, datapath command and status structs, register map.
// ----------------------------------------------------------------------------
package bcpe_pkg;

  typedef enum logic [1:0] {
    OP_WR_POINT  = 2'd0,
    OP_WR_WEIGHT = 2'd1,
    OP_WR_DUR    = 2'd2,
    OP_EVAL      = 2'd3
  } item_op_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_DUR,
    CMD_DIV_INIT,
    CMD_TAU_ONE,
    CMD_DIV_STEP,
    CMD_TAU_Q,
    CMD_BAS_INIT,
    CMD_BAS_MUL,
    CMD_WB,
    CMD_RD_PT,
    CMD_MAG,
    CMD_PART,
    CMD_ACC,
    CMD_OUT,
    CMD_OUT_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       sel_tau;
    logic       axis;
    logic [1:0] part;
  } dp_cmd_t;

  typedef struct packed {
    logic seg_ok;
    logic time_ge_dur;
  } dp_status_t;

  localparam int          ORDER_W     = 3;
  localparam logic [2:0]  ORDER_RESET = 3'd5;
  localparam int          APB_AW      = 2;
  localparam int          APB_DW      = 32;

endpackage

@@ rtl/bcpe_dp.sv @@
// ----------------------------------------------------------------------------
// bcpe_dp
// Datapath: point, weight and duration stores, tau divider, one shared
// 32x32 multiplier, term accumulators and output registers.
// ----------------------------------------------------------------------------
module bcpe_dp #(
  parameter int MAX_POINTS   = 8,
  parameter int NUM_SEGMENTS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic                         clk,
  input  logic [1:0]                   in_op,
  input  logic [2:0]                   in_segment,
  input  logic                         in_axis,
  input  logic [2:0]                   in_point_index,
  input  logic signed [31:0]           in_data_value,
  input  logic [31:0]                  in_time_value,
  input  logic [$clog2(MAX_POINTS)-1:0] j_idx,
  input  bcpe_pkg::dp_cmd_t            cmd,
  output bcpe_pkg::dp_status_t         status,
  output logic signed [31:0]           out_pos_x,
  output logic signed [31:0]           out_pos_y
);
  import bcpe_pkg::*;

  localparam int SEG_W = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CP_AW = SEG_W + 1 + IDX_W;
  localparam int FX_W  = FRAC_BITS + 1;
  localparam logic [FX_W-1:0] ONE_FX   = FX_W'(1) << FRAC_BITS;
  localparam logic [62:0]     TERM_CAP = 63'(1) << 62;
  localparam logic signed [64:0] ACC_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] ACC_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  logic [31:0] cp_mem  [2**CP_AW];
  logic [15:0] w_mem   [2**IDX_W];
  logic [31:0] dur_mem [2**SEG_W];

  logic              seg_ok_r;
  logic [SEG_W-1:0]  seg_a_r;
  logic [31:0]       time_r, dur_r, rem_r, dur_q, cp_q;
  logic [FRAC_BITS-1:0] quo_r;
  logic [FX_W-1:0]   tau_r, omt_r, p_r;
  logic [15:0]       w_q;
  logic [63:0]       wb_r, a_r;
  logic              neg_r;
  logic [127:0]      prod_r;
  logic signed [63:0] acc_x_r, acc_y_r;
  logic signed [31:0] pos_x_r, pos_y_r;

  logic              in_seg_ok, in_idx_ok;
  logic [SEG_W-1:0]  in_seg_a;
  logic [IDX_W-1:0]  in_idx_a;
  logic [32:0]       rem2;
  logic              rem_ge;
  logic [31:0]       mul_a, mul_b, mag;
  logic [63:0]       mul_p;
  logic [127:0]      part_sh, t_full;
  logic [62:0]       t_cap;
  logic signed [64:0] term_s, sum_s;
  logic signed [63:0] acc_sel, acc_new;

  assign in_seg_ok = 32'(in_segment) < NUM_SEGMENTS;
  assign in_idx_ok = 32'(in_point_index) < MAX_POINTS;
  assign in_seg_a  = SEG_W'(in_segment);
  assign in_idx_a  = IDX_W'(in_point_index);

  assign status.seg_ok      = seg_ok_r;
  assign status.time_ge_dur = time_r >= dur_r;

  // one restoring step of time * 2^F / dur
  assign rem2   = {rem_r, 1'b0};
  assign rem_ge = rem2 >= {1'b0, dur_r};

  assign mag = cp_q[31] ? (~cp_q + 32'd1) : cp_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      CMD_BAS_MUL: begin
        mul_a = 32'(p_r);
        mul_b = cmd.sel_tau ? 32'(tau_r) : 32'(omt_r);
      end
      CMD_WB: begin
        mul_a = 32'(w_q);
        mul_b = 32'(p_r);
      end
      CMD_MAG: begin
        mul_a = mag;
        mul_b = dur_r;
      end
      CMD_PART: begin
        mul_a = cmd.part[0] ? a_r[63:32] : a_r[31:0];
        mul_b = cmd.part[1] ? wb_r[63:32] : wb_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    case (cmd.part)
      2'd0:    part_sh = {64'b0, mul_p};
      2'd3:    part_sh = {mul_p, 64'b0};
      default: part_sh = {32'b0, mul_p, 32'b0};
    endcase
  end

  // cap the term, apply the point sign, saturate the running sum
  assign t_full  = prod_r >> FRAC_BITS;
  assign t_cap   = (t_full > {65'b0, TERM_CAP}) ? TERM_CAP : t_full[62:0];
  assign term_s  = neg_r ? -$signed({2'b0, t_cap}) : $signed({2'b0, t_cap});
  assign acc_sel = cmd.axis ? acc_y_r : acc_x_r;
  assign sum_s   = $signed({acc_sel[63], acc_sel}) + term_s;

  always_comb begin
    if (sum_s > ACC_MAX) begin
      acc_new = ACC_MAX[63:0];
    end else if (sum_s < ACC_MIN) begin
      acc_new = ACC_MIN[63:0];
    end else begin
      acc_new = sum_s[63:0];
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // stores
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      if (in_op == OP_WR_POINT && in_seg_ok && in_idx_ok) begin
        cp_mem[{in_seg_a, in_axis, in_idx_a}] <= in_data_value;
      end
      if (in_op == OP_WR_WEIGHT && in_idx_ok) begin
        w_mem[in_idx_a] <= in_data_value[15:0];
      end
      if (in_op == OP_WR_DUR && in_seg_ok) begin
        dur_mem[in_seg_a] <= in_data_value;
      end
    end
    if (cmd.op == CMD_RD_DUR) begin
      dur_q <= dur_mem[seg_a_r];
    end
    if (cmd.op == CMD_BAS_INIT) begin
      w_q <= w_mem[j_idx];
    end
    if (cmd.op == CMD_RD_PT) begin
      cp_q <= cp_mem[{seg_a_r, cmd.axis, j_idx}];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        seg_ok_r <= in_seg_ok;
        seg_a_r  <= in_seg_a;
        time_r   <= in_time_value;
      end
      CMD_DIV_INIT: begin
        dur_r   <= (dur_q[31] || dur_q == 32'd0) ? 32'd1 : dur_q;
        rem_r   <= time_r;
        quo_r   <= '0;
        acc_x_r <= '0;
        acc_y_r <= '0;
      end
      CMD_TAU_ONE: begin
        tau_r <= ONE_FX;
        omt_r <= '0;
      end
      CMD_DIV_STEP: begin
        rem_r <= rem_ge ? 32'(rem2 - {1'b0, dur_r}) : rem2[31:0];
        quo_r <= {quo_r[FRAC_BITS-2:0], rem_ge};
      end
      CMD_TAU_Q: begin
        tau_r <= FX_W'(quo_r);
        omt_r <= ONE_FX - FX_W'(quo_r);
      end
      CMD_BAS_INIT: p_r <= ONE_FX;
      CMD_BAS_MUL:  p_r <= FX_W'(mul_p >> FRAC_BITS);
      CMD_WB:       wb_r <= mul_p;
      CMD_MAG: begin
        a_r   <= mul_p >> FRAC_BITS;
        neg_r <= cp_q[31];
      end
      CMD_PART: begin
        prod_r <= (cmd.part == 2'd0) ? part_sh : prod_r + part_sh;
      end
      CMD_ACC: begin
        if (cmd.axis) begin
          acc_y_r <= acc_new;
        end else begin
          acc_x_r <= acc_new;
        end
      end
      CMD_OUT: begin
        pos_x_r <= sat32(acc_x_r);
        pos_y_r <= sat32(acc_y_r);
      end
      CMD_OUT_ZERO: begin
        pos_x_r <= '0;
        pos_y_r <= '0;
      end
      default: begin
      end
    endcase
  end

  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;

endmodule

@@ rtl/bcpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcpe_ctrl
// Sequencer: walks divide, basis products and per-point terms, and owns
// the input and result handshakes.
// ----------------------------------------------------------------------------
module bcpe_ctrl #(
  parameter int MAX_POINTS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic [2:0]                    curve_order,
  input  bcpe_pkg::dp_status_t          status,
  output bcpe_pkg::dp_cmd_t             cmd,
  output logic [$clog2(MAX_POINTS)-1:0] j_idx
);
  import bcpe_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int DIV_W = $clog2(FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DIVI, S_DCMP, S_DIV, S_DDONE, S_BINIT, S_BMUL,
    S_BWB, S_PRD, S_PA, S_PT, S_PACC, S_FIN
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] j_r, last_j;
  logic [2:0]       k_r;
  logic [1:0]       pp_r;
  logic             ax_r;
  logic [DIV_W-1:0] div_r;
  logic             out_valid_r;
  logic             in_fire, fin_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign j_idx     = j_r;

  assign last_j = (32'(curve_order) + 1 > MAX_POINTS) ? IDX_W'(MAX_POINTS - 1)
                                                      : IDX_W'(curve_order);

  always_comb begin
    cmd.op      = CMD_NONE;
    cmd.sel_tau = 32'(k_r) < 32'(j_r);
    cmd.axis    = ax_r;
    cmd.part    = pp_r;
    case (state_r)
      S_IDLE:  cmd.op = in_fire ? CMD_LOAD : CMD_NONE;
      S_CHK:   cmd.op = CMD_RD_DUR;
      S_DIVI:  cmd.op = CMD_DIV_INIT;
      S_DCMP:  cmd.op = status.time_ge_dur ? CMD_TAU_ONE : CMD_NONE;
      S_DIV:   cmd.op = CMD_DIV_STEP;
      S_DDONE: cmd.op = CMD_TAU_Q;
      S_BINIT: cmd.op = CMD_BAS_INIT;
      S_BMUL:  cmd.op = CMD_BAS_MUL;
      S_BWB:   cmd.op = CMD_WB;
      S_PRD:   cmd.op = CMD_RD_PT;
      S_PA:    cmd.op = CMD_MAG;
      S_PT:    cmd.op = CMD_PART;
      S_PACC:  cmd.op = CMD_ACC;
      S_FIN: begin
        if (fin_load) begin
          cmd.op = status.seg_ok ? CMD_OUT : CMD_OUT_ZERO;
        end
      end
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      k_r         <= '0;
      pp_r        <= '0;
      ax_r        <= 1'b0;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_op == OP_EVAL) begin
            state_r <= S_CHK;
          end
        end
        S_CHK:  state_r <= status.seg_ok ? S_DIVI : S_FIN;
        S_DIVI: state_r <= S_DCMP;
        S_DCMP: begin
          j_r   <= '0;
          div_r <= '0;
          state_r <= status.time_ge_dur ? S_BINIT : S_DIV;
        end
        S_DIV: begin
          div_r <= div_r + 1'b1;
          if (32'(div_r) == FRAC_BITS - 1) begin
            state_r <= S_DDONE;
          end
        end
        S_DDONE: state_r <= S_BINIT;
        S_BINIT: begin
          k_r     <= '0;
          state_r <= (curve_order == 3'd0) ? S_BWB : S_BMUL;
        end
        S_BMUL: begin
          k_r <= k_r + 1'b1;
          if (k_r == curve_order - 3'd1) begin
            state_r <= S_BWB;
          end
        end
        S_BWB: begin
          ax_r    <= 1'b0;
          state_r <= S_PRD;
        end
        S_PRD: state_r <= S_PA;
        S_PA: begin
          pp_r    <= '0;
          state_r <= S_PT;
        end
        S_PT: begin
          pp_r <= pp_r + 1'b1;
          if (pp_r == 2'd3) begin
            state_r <= S_PACC;
          end
        end
        S_PACC: begin
          if (!ax_r) begin
            ax_r    <= 1'b1;
            state_r <= S_PRD;
          end else if (j_r == last_j) begin
            state_r <= S_FIN;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_BINIT;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pp_only_in_part: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PT && state_r != S_PACC) |-> (pp_r == 2'd0 || state_r != S_PA))
    else $error("partial product counter out of step");

  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BINIT || state_r == S_PACC) |-> (j_r <= last_j))
    else $error("point index beyond last point");

  a_k_below_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BMUL) |-> (k_r < curve_order))
    else $error("basis exponent count overran order");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result overwritten while still pending");
`endif

endmodule

@@ rtl/bezier_curve_point_evaluator.sv @@
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator
// 2-D Bezier point evaluation in Bernstein form over stored control points,
// binomial weights and segment durations.
//
//   channel   handshake            payload
//   in        in_valid/in_ready    in_op, in_segment, in_axis,
//                                  in_point_index, in_data_value, in_time_value
//   out       out_valid/out_ready  out_pos_x, out_pos_y
//   cfg       psel/penable/pready  paddr, pwdata, prdata (curve_order at 0)
//
// An evaluate runs the bit-serial tau divider (no divide when
//   time >= duration), then for each of npts = min(curve_order + 1,
//   MAX_POINTS) points the basis and term products on the single
//   shared 32x32 multiplier.
// Reset (rst_n, synchronous) clears control and sets curve_order to 5.
// A pending result does not block the next transaction from being accepted.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator #(
  parameter int MAX_POINTS   = 8,
  parameter int NUM_SEGMENTS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [2:0]                     in_segment,
  input  logic                           in_axis,
  input  logic [2:0]                     in_point_index,
  input  logic signed [31:0]             in_data_value,
  input  logic [31:0]                    in_time_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_pos_x,
  output logic signed [31:0]             out_pos_y,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcpe_pkg::APB_AW-1:0]    paddr,
  input  logic [bcpe_pkg::APB_DW-1:0]    pwdata,
  output logic [bcpe_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import bcpe_pkg::*;

  logic [ORDER_W-1:0]            order_r;
  dp_cmd_t                       cmd;
  dp_status_t                    status;
  logic [$clog2(MAX_POINTS)-1:0] j_idx;

  assign pready = 1'b1;
  assign prdata = {(APB_DW - ORDER_W)'(0), order_r};

  // single register; every address in the small window maps to it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (psel && penable && pwrite && pready && paddr <= APB_AW'(3)) begin
      order_r <= pwdata[ORDER_W-1:0];
    end
  end

  bcpe_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_order (order_r),
    .status      (status),
    .cmd         (cmd),
    .j_idx       (j_idx)
  );

  bcpe_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .in_op          (in_op),
    .in_segment     (in_segment),
    .in_axis        (in_axis),
    .in_point_index (in_point_index),
    .in_data_value  (in_data_value),
    .in_time_value  (in_time_value),
    .j_idx          (j_idx),
    .cmd            (cmd),
    .status         (status),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y)
  );

endmodule
